// File: hdl/smtt_pkg.sv
// Shared constants, control word type and microcode table for the triplet transpose unit.
`timescale 1ns / 1ps

package smtt_pkg;

  localparam int MAX_ROWS    = 4;
  localparam int MAX_COLS    = 4;
  localparam int VALUE_WIDTH = 32;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIM_W  = 3;
  localparam int STEP_W = 3;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  // Microcode step addresses.
  localparam step_t STEP_LOAD   = 3'd0;
  localparam step_t STEP_HDR0   = 3'd1;
  localparam step_t STEP_READ0  = 3'd2;
  localparam step_t STEP_EMIT0  = 3'd3;
  localparam step_t STEP_HDR1   = 3'd4;
  localparam step_t STEP_READ1  = 3'd5;
  localparam step_t STEP_EMIT1  = 3'd6;

  typedef enum logic {
    COND_ALWAYS = 1'b0,
    COND_AT_END = 1'b1
  } cond_t;

  typedef struct packed {
    logic  take_in;    // accept an element and store it
    logic  emit_hdr;   // emit a list header
    logic  emit_ent;   // emit the entry just read if it is nonzero
    logic  list_id;    // which list this step belongs to
    logic  rd_en;      // issue a store read at the scan position
    logic  col_major;  // scan order: column by column when set
    logic  clr_idx;    // reset the scan position and the emitted count
    logic  clr_nz;     // reset the nonzero count when the jump is taken
    cond_t cond;       // jump condition
    step_t tgt_t;      // next step when the condition holds
    step_t tgt_f;      // next step otherwise
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t cw;
    cw = '{take_in: 1'b0, emit_hdr: 1'b0, emit_ent: 1'b0, list_id: 1'b0, rd_en: 1'b0,
           col_major: 1'b0, clr_idx: 1'b0, clr_nz: 1'b0, cond: COND_ALWAYS,
           tgt_t: STEP_LOAD, tgt_f: STEP_LOAD};
    case (pc)
      STEP_LOAD: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_AT_END;
        cw.tgt_t   = STEP_HDR0;
        cw.tgt_f   = STEP_LOAD;
      end
      STEP_HDR0: begin
        cw.emit_hdr = 1'b1;
        cw.clr_idx  = 1'b1;
        cw.tgt_t    = STEP_READ0;
      end
      STEP_READ0: begin
        cw.rd_en = 1'b1;
        cw.tgt_t = STEP_EMIT0;
      end
      STEP_EMIT0: begin
        cw.emit_ent = 1'b1;
        cw.cond     = COND_AT_END;
        cw.tgt_t    = STEP_HDR1;
        cw.tgt_f    = STEP_READ0;
      end
      STEP_HDR1: begin
        cw.emit_hdr = 1'b1;
        cw.list_id  = 1'b1;
        cw.clr_idx  = 1'b1;
        cw.tgt_t    = STEP_READ1;
      end
      STEP_READ1: begin
        cw.rd_en     = 1'b1;
        cw.list_id   = 1'b1;
        cw.col_major = 1'b1;
        cw.tgt_t     = STEP_EMIT1;
      end
      STEP_EMIT1: begin
        cw.emit_ent  = 1'b1;
        cw.list_id   = 1'b1;
        cw.col_major = 1'b1;
        cw.clr_nz    = 1'b1;
        cw.cond      = COND_AT_END;
        cw.tgt_t     = STEP_LOAD;
        cw.tgt_f     = STEP_READ1;
      end
      default: begin
        cw.tgt_t = STEP_LOAD;
      end
    endcase
    return cw;
  endfunction

  // A zero dimension acts as one, an oversized one as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: hdl/smtt_store.sv
// Element store of the triplet transpose unit: one write port and one registered read port.
`timescale 1ns / 1ps

module smtt_store (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [smtt_pkg::ADDR_W-1:0]        wr_addr,
  input  logic [smtt_pkg::VALUE_WIDTH-1:0]   wr_data,
  input  logic                               rd_en,
  input  logic [smtt_pkg::ADDR_W-1:0]        rd_addr,
  output logic [smtt_pkg::VALUE_WIDTH-1:0]   rd_data
);

  logic [smtt_pkg::VALUE_WIDTH-1:0] mem [smtt_pkg::DEPTH];
  logic [smtt_pkg::VALUE_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/sparse_matrix_triplet_transpose_unit.sv
// Top level of the sparse matrix triplet builder with simple transpose.
`timescale 1ns / 1ps
// Elements load at one per cycle; after the last element the sequencer moves to the header
// step of the triplet list, and the scan then visits each matrix position in two steps
// (store read, then check and emit); a header or nonzero entry waits while the output is held.
// Input is taken at one element per cycle during loading; the store's single read port sets the
// scan rate. Reset (synchronous, active low) sets 4 by 4 dimensions and an empty matrix.

module sparse_matrix_triplet_transpose_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_element_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_list_id,
  output logic        out_is_header,
  output logic [2:0]  out_first_index,
  output logic [2:0]  out_second_index,
  output logic signed [31:0] out_entry_value,
  output logic        out_last_of_run
);

  // Configuration registers hold the raw written values; clamping happens on use.
  logic [smtt_pkg::DIM_W-1:0] rows_r, rows_nxt;
  logic [smtt_pkg::DIM_W-1:0] cols_r, cols_nxt;
  logic [smtt_pkg::DIM_W-1:0] rows_eff, cols_eff;

  // Sequencer state.
  smtt_pkg::step_t pc_r, pc_nxt;
  smtt_pkg::ctrl_t cw;

  // Datapath registers: the position counters serve both loading and scanning.
  logic [smtt_pkg::ROW_W-1:0] pos_r_r, pos_r_nxt;
  logic [smtt_pkg::COL_W-1:0] pos_c_r, pos_c_nxt;
  logic [smtt_pkg::CNT_W-1:0] nz_r, nz_nxt;
  logic [smtt_pkg::CNT_W-1:0] seen_r, seen_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_list_r;
  logic                               out_hdr_r;
  logic [2:0]                         out_first_r;
  logic [2:0]                         out_second_r;
  logic [31:0]                        out_value_r;
  logic                               out_last_r;

  logic                               at_end;
  logic                               row_end;
  logic                               col_end;
  logic                               out_free;
  logic                               ent_nz;
  logic                               go;
  logic                               cond_ok;
  logic                               load_out;
  logic                               advance;
  logic [smtt_pkg::ADDR_W-1:0]        addr;
  logic [smtt_pkg::VALUE_WIDTH-1:0]   rd_data;
  logic [smtt_pkg::VALUE_WIDTH-1:0]   elem;
  logic                               in_take;

  assign rows_eff = smtt_pkg::clamp_dim(rows_r, smtt_pkg::DIM_W'(smtt_pkg::MAX_ROWS));
  assign cols_eff = smtt_pkg::clamp_dim(cols_r, smtt_pkg::DIM_W'(smtt_pkg::MAX_COLS));

  assign row_end = (smtt_pkg::DIM_W'(pos_r_r) == rows_eff - smtt_pkg::DIM_W'(1));
  assign col_end = (smtt_pkg::DIM_W'(pos_c_r) == cols_eff - smtt_pkg::DIM_W'(1));
  // The final position is the bottom right corner in either scan order.
  assign at_end  = row_end && col_end;

  assign addr = smtt_pkg::ADDR_W'(pos_r_r) * smtt_pkg::ADDR_W'(smtt_pkg::MAX_COLS)
              + smtt_pkg::ADDR_W'(pos_c_r);

  assign elem = in_element_value[smtt_pkg::VALUE_WIDTH-1:0];

  smtt_store u_store (
    .clk     (clk),
    .wr_en   (in_take),
    .wr_addr (addr),
    .wr_data (elem),
    .rd_en   (cw.rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // The current microcode word drives everything below.
  assign cw       = smtt_pkg::ucode(pc_r);
  assign in_stall = !cw.take_in;
  assign in_take  = cw.take_in && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign ent_nz   = (rd_data != '0);

  // A step completes once its transfer, if any, can happen.
  always_comb begin
    if (cw.take_in) begin
      go = in_valid;
    end else if (cw.emit_hdr) begin
      go = out_free;
    end else if (cw.emit_ent) begin
      go = !ent_nz || out_free;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    case (cw.cond)
      smtt_pkg::COND_ALWAYS: cond_ok = 1'b1;
      smtt_pkg::COND_AT_END: cond_ok = at_end;
      default:               cond_ok = 1'b1;
    endcase
  end

  assign pc_nxt   = go ? (cond_ok ? cw.tgt_t : cw.tgt_f) : pc_r;
  assign load_out = go && (cw.emit_hdr || (cw.emit_ent && ent_nz));
  assign advance  = go && (cw.take_in || cw.emit_ent);

  // Position counters step row by row while loading and in the first list, column by
  // column in the transposed list; they wrap to the origin after the final position.
  always_comb begin
    pos_r_nxt = pos_r_r;
    pos_c_nxt = pos_c_r;
    if (cfg_wr_en || (go && cw.clr_idx)) begin
      pos_r_nxt = '0;
      pos_c_nxt = '0;
    end else if (advance) begin
      if (at_end) begin
        pos_r_nxt = '0;
        pos_c_nxt = '0;
      end else if (cw.col_major) begin
        if (row_end) begin
          pos_r_nxt = '0;
          pos_c_nxt = pos_c_r + smtt_pkg::COL_W'(1);
        end else begin
          pos_r_nxt = pos_r_r + smtt_pkg::ROW_W'(1);
        end
      end else begin
        if (col_end) begin
          pos_c_nxt = '0;
          pos_r_nxt = pos_r_r + smtt_pkg::ROW_W'(1);
        end else begin
          pos_c_nxt = pos_c_r + smtt_pkg::COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    nz_nxt = nz_r;
    if (cfg_wr_en || (go && cw.clr_nz && cond_ok)) begin
      nz_nxt = '0;
    end else if (in_take && (elem != '0)) begin
      nz_nxt = nz_r + smtt_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (go && cw.clr_idx) begin
      seen_nxt = '0;
    end else if (load_out && cw.emit_ent) begin
      seen_nxt = seen_r + smtt_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        smtt_pkg::REG_ROW_COUNT: rows_nxt = cfg_data;
        smtt_pkg::REG_COL_COUNT: cols_nxt = cfg_data;
        default: begin
          rows_nxt = rows_r;
        end
      endcase
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= smtt_pkg::STEP_LOAD;
      rows_r      <= smtt_pkg::DIM_W'(smtt_pkg::MAX_ROWS);
      cols_r      <= smtt_pkg::DIM_W'(smtt_pkg::MAX_COLS);
      pos_r_r     <= '0;
      pos_c_r     <= '0;
      nz_r        <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      pos_r_r     <= pos_r_nxt;
      pos_c_r     <= pos_c_nxt;
      nz_r        <= nz_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Headers carry the dimensions and the nonzero count; entries carry the scan position,
  // swapped for the transposed list. The last flag marks the final transposed entry, or
  // the transposed header when the matrix has no nonzeros.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_list_r <= cw.list_id;
      out_hdr_r  <= cw.emit_hdr;
      if (cw.emit_hdr) begin
        out_first_r  <= cw.list_id ? cols_eff : rows_eff;
        out_second_r <= cw.list_id ? rows_eff : cols_eff;
        out_value_r  <= 32'(nz_r);
        out_last_r   <= cw.list_id && (nz_r == '0);
      end else begin
        out_first_r  <= cw.list_id ? 3'(pos_c_r) : 3'(pos_r_r);
        out_second_r <= cw.list_id ? 3'(pos_r_r) : 3'(pos_c_r);
        out_value_r  <= 32'(rd_data);
        out_last_r   <= cw.list_id && ((seen_r + smtt_pkg::CNT_W'(1)) == nz_r);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_list_id      = out_list_r;
  assign out_is_header    = out_hdr_r;
  assign out_first_index  = out_first_r;
  assign out_second_index = out_second_r;
  assign out_entry_value  = out_value_r;
  assign out_last_of_run  = out_last_r;

  // The output register is only overwritten once its previous transfer has gone out.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while a transfer was pending");

  // The nonzero count never exceeds the number of store entries.
  a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nz_r <= smtt_pkg::CNT_W'(smtt_pkg::DEPTH))
    else $error("nonzero count out of range");

  // After the final transposed entry leaves the sequencer, it is back to loading.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (pc_r == smtt_pkg::STEP_EMIT1) && at_end) |=> (pc_r == smtt_pkg::STEP_LOAD))
    else $error("sequencer did not return to loading after the transposed list");

  // A scan step never runs past the program.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= smtt_pkg::STEP_EMIT1)
    else $error("step counter outside the program");

endmodule
